// ----- hdl/nn_activation_unit_macros.svh -----
// Assertion macros for the activation unit checker.
// Needs clock and reset in the scope of each use.
`ifndef NN_ACTIVATION_UNIT_MACROS_SVH
`define NN_ACTIVATION_UNIT_MACROS_SVH

// check a condition at every clock edge outside reset
`define NNAU_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// check a consequence in the same cycle
`define NNAU_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check a consequence in the next cycle
`define NNAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/nnau_pkg.sv -----
// Shared types, constants and table builder for the activation unit.
// No dependencies.
package nnau_pkg;

   localparam int DATA_W          = 16;
   localparam int FRAC_BITS_DEF   = 12;
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int TAB_Q           = 30;
   localparam int TW              = TAB_Q + 1;
   localparam int DW              = TW + 1;
   localparam int ROM_W           = 4 * TW;
   localparam int PIPE_DEPTH      = 5;

   typedef enum logic [2:0] {
      FN_HARDLIM  = 3'd0,
      FN_HARDLIMS = 3'd1,
      FN_LINEAR   = 3'd2,
      FN_SATLIN   = 3'd3,
      FN_SATLINS  = 3'd4,
      FN_LOGSIG   = 3'd5,
      FN_TANSIG   = 3'd6,
      FN_RELU     = 3'd7
   } fn_type;

   // field position inside one table word
   localparam logic [1:0] FLD_DTAN = 2'd0;
   localparam logic [1:0] FLD_TAN  = 2'd1;
   localparam logic [1:0] FLD_DLOG = 2'd2;
   localparam logic [1:0] FLD_LOG  = 2'd3;

   // shift and subtract quotient, applied to constant table arguments only
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [ROM_W-1:0] rom_entry(input int unsigned depth,
                                                  input int unsigned idx);
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      longint unsigned e;
      longint unsigned f;
      longint unsigned lg;
      longint unsigned dlg;
      longint unsigned tn;
      longint unsigned dtn;
      longint unsigned one;
      int unsigned     k;
      int unsigned     i;
      one  = 64'd1 << TAB_Q;
      term = 64'd1 << 40;
      sum  = term;
      for (k = 1; k <= 20; k++) begin
         term = udiv(term * 64'd8, 64'(depth) * 64'(k));
         if (k[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + 64'd512) >> 10;
      e = one;
      for (i = 1; i <= idx; i++) begin
         e = (e * r + (one >> 1)) >> TAB_Q;
      end
      f   = (e * e) >> TAB_Q;
      lg  = udiv(64'd1 << 60, one + e);
      dlg = (lg * (one - lg)) >> TAB_Q;
      tn  = udiv((one - f) << TAB_Q, one + f);
      dtn = one - ((tn * tn) >> TAB_Q);
      return {lg[TW-1:0], dlg[TW-1:0], tn[TW-1:0], dtn[TW-1:0]};
   endfunction

endpackage

// ----- hdl/nn_activation_unit.sv -----
// Activation function unit: value or derivative of a selectable transfer function.
// Depends on nnau_pkg for codes, widths and the table builder.
//
// channel  direction  handshake              payload
// req      in         req_valid/req_stall    req_operation, req_sample_in
// rsp      out        rsp_valid/rsp_stall    rsp_result_out
// csr      in         csr_valid/csr_ready    csr_function_select
//
// One transaction per cycle while req_stall is low; each passes the address, table word,
// product, rounded value and result registers in order, and rsp_valid follows the last.
// Reset clears all stage valids and sets function_select to linear.
// While rsp_stall holds the output register, earlier stages keep filling until five
// transactions are in flight, then req_stall rises.
module nn_activation_unit #(
   parameter int FRAC_BITS   = nnau_pkg::FRAC_BITS_DEF,
   parameter int TABLE_DEPTH = nnau_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic signed [nnau_pkg::DATA_W-1:0] req_sample_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [nnau_pkg::DATA_W-1:0] rsp_result_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_function_select
);

   localparam int DATA_W = nnau_pkg::DATA_W;
   localparam int TW     = nnau_pkg::TW;
   localparam int DW     = nnau_pkg::DW;
   localparam int ROM_W  = nnau_pkg::ROM_W;
   localparam int AW     = $clog2(TABLE_DEPTH + 1);
   localparam int SW     = FRAC_BITS + 3;
   localparam int PW0    = DATA_W + AW;
   localparam int PW     = (PW0 > SW) ? PW0 : SW + 1;
   localparam int IW     = PW - SW;
   localparam int PRW    = DW + SW + 1;
   localparam int RS     = nnau_pkg::TAB_Q - FRAC_BITS;
   localparam int LW     = DW - RS;
   localparam int YW     = ((FRAC_BITS > DATA_W) ? FRAC_BITS : DATA_W) + 3;

   localparam logic signed [PRW-1:0] SPAN_M1  = PRW'((64'd1 << SW) - 64'd1);
   localparam logic signed [DW-1:0]  HALF_LSB = DW'(64'd1 << (RS - 1));
   localparam logic signed [YW-1:0]  ONE_Y    = YW'(64'd1 << FRAC_BITS);
   localparam logic signed [YW-1:0]  ZERO_Y   = '0;
   localparam logic signed [YW-1:0]  SAT_HI   = YW'(32767);
   localparam logic signed [YW-1:0]  SAT_LO   = YW'(-32768);

   // constant table, one word per breakpoint
   logic [ROM_W-1:0] rom_word [0:TABLE_DEPTH];

   for (genvar gi = 0; gi <= TABLE_DEPTH; gi++) begin : g_rom
      assign rom_word[gi] = nnau_pkg::rom_entry(TABLE_DEPTH, gi);
   end

   nnau_pkg::fn_type fsel_ff, fsel_in;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_free, s2_free, s3_free, s4_free, out_free;

   logic                     deriv1_ff, deriv1_in;
   logic signed [DATA_W-1:0] x1_ff, x1_in;
   logic [AW-1:0]            addr_a1_ff, addr_a1_in, addr_b1_ff, addr_b1_in;
   logic [SW-1:0]            frac1_ff, frac1_in;

   logic                     deriv2_ff;
   logic signed [DATA_W-1:0] x2_ff;
   logic [SW-1:0]            frac2_ff;
   logic [ROM_W-1:0]         worda2_ff, worda2_in, wordb2_ff, wordb2_in;

   logic                     deriv3_ff;
   logic signed [DATA_W-1:0] x3_ff;
   logic signed [DW-1:0]     a3_ff, a3_in;
   logic signed [PRW-1:0]    prod3_ff, prod3_in;

   logic                     deriv4_ff;
   logic signed [DATA_W-1:0] x4_ff;
   logic [LW-1:0]            lut4_ff, lut4_in;

   logic signed [DATA_W-1:0] rsp_result_out_ff, rsp_result_out_in;

   logic [DATA_W-1:0]     mag;
   logic [PW-1:0]         p_full;
   logic [IW-1:0]         idx_full;
   logic                  past_end;
   logic [1:0]            fld;
   logic [TW-1:0]         fa, fb;
   logic signed [DW-1:0]  diff;
   logic signed [PRW-1:0] q_full;
   logic signed [DW-1:0]  v_lin, v_rnd;
   logic signed [YW-1:0]  xw, lutw, y;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s4_free   = !v4_ff || out_free;
   assign s3_free   = !v3_ff || s4_free;
   assign s2_free   = !v2_ff || s3_free;
   assign s1_free   = !v1_ff || s2_free;
   assign req_stall = !s1_free;
   assign csr_ready = 1'b1;

   assign v1_in        = s1_free  ? req_valid : v1_ff;
   assign v2_in        = s2_free  ? v1_ff     : v2_ff;
   assign v3_in        = s3_free  ? v2_ff     : v3_ff;
   assign v4_in        = s4_free  ? v3_ff     : v4_ff;
   assign rsp_valid_in = out_free ? v4_ff     : rsp_valid_ff;

   assign fsel_in = (csr_valid && csr_ready) ? nnau_pkg::fn_type'(csr_function_select)
                                             : fsel_ff;

   // address and fraction of the interpolation interval
   always_comb begin
      mag      = req_sample_in[DATA_W-1] ? $unsigned(DATA_W'(-req_sample_in))
                                         : $unsigned(req_sample_in);
      p_full   = PW'(mag) * PW'(TABLE_DEPTH);
      idx_full = p_full[PW-1:SW];
      past_end = 32'(idx_full) >= 32'(TABLE_DEPTH);
      deriv1_in  = req_operation;
      x1_in      = req_sample_in;
      addr_a1_in = past_end ? AW'(TABLE_DEPTH) : AW'(idx_full);
      addr_b1_in = past_end ? AW'(TABLE_DEPTH) : AW'(idx_full) + AW'(1);
      frac1_in   = past_end ? '0 : p_full[SW-1:0];
   end

   assign worda2_in = rom_word[addr_a1_ff];
   assign wordb2_in = rom_word[addr_b1_ff];

   always_comb begin
      if (fsel_ff == nnau_pkg::FN_TANSIG) begin
         fld = deriv2_ff ? nnau_pkg::FLD_DTAN : nnau_pkg::FLD_TAN;
      end else begin
         fld = deriv2_ff ? nnau_pkg::FLD_DLOG : nnau_pkg::FLD_LOG;
      end
      fa       = worda2_ff[fld * TW +: TW];
      fb       = wordb2_ff[fld * TW +: TW];
      diff     = $signed({1'b0, fb}) - $signed({1'b0, fa});
      a3_in    = $signed({1'b0, fa});
      prod3_in = PRW'(diff) * PRW'($signed({1'b0, frac2_ff}));
   end

   // truncate toward zero, then round half up
   always_comb begin
      q_full  = prod3_ff[PRW-1] ? ((prod3_ff + SPAN_M1) >>> SW) : (prod3_ff >>> SW);
      v_lin   = a3_ff + q_full[DW-1:0];
      v_rnd   = v_lin + HALF_LSB;
      lut4_in = v_rnd[DW-1:RS];
   end

   always_comb begin
      xw   = YW'(x4_ff);
      lutw = YW'($signed({1'b0, lut4_ff}));
      y    = ZERO_Y;
      unique case (fsel_ff)
         nnau_pkg::FN_HARDLIM: begin
            y = deriv4_ff ? ZERO_Y : ((xw >= ZERO_Y) ? ONE_Y : ZERO_Y);
         end
         nnau_pkg::FN_HARDLIMS: begin
            y = deriv4_ff ? ZERO_Y : ((xw >= ZERO_Y) ? ONE_Y : -ONE_Y);
         end
         nnau_pkg::FN_LINEAR: begin
            y = deriv4_ff ? ONE_Y : xw;
         end
         nnau_pkg::FN_SATLIN: begin
            if (deriv4_ff) begin
               y = (xw > ZERO_Y && xw < ONE_Y) ? ONE_Y : ZERO_Y;
            end else begin
               y = (xw > ONE_Y) ? ONE_Y : ((xw < ZERO_Y) ? ZERO_Y : xw);
            end
         end
         nnau_pkg::FN_SATLINS: begin
            if (deriv4_ff) begin
               y = (xw > -ONE_Y && xw < ONE_Y) ? ONE_Y : ZERO_Y;
            end else begin
               y = (xw > ONE_Y) ? ONE_Y : ((xw < -ONE_Y) ? -ONE_Y : xw);
            end
         end
         nnau_pkg::FN_LOGSIG: begin
            y = (!deriv4_ff && x4_ff[DATA_W-1]) ? (ONE_Y - lutw) : lutw;
         end
         nnau_pkg::FN_TANSIG: begin
            y = (!deriv4_ff && x4_ff[DATA_W-1]) ? -lutw : lutw;
         end
         nnau_pkg::FN_RELU: begin
            if (deriv4_ff) begin
               y = (xw > ZERO_Y) ? ONE_Y : ZERO_Y;
            end else begin
               y = (xw >= ZERO_Y) ? xw : ZERO_Y;
            end
         end
      endcase
      if (y > SAT_HI) begin
         rsp_result_out_in = DATA_W'(SAT_HI);
      end else if (y < SAT_LO) begin
         rsp_result_out_in = DATA_W'(SAT_LO);
      end else begin
         rsp_result_out_in = y[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff      <= nnau_pkg::FN_LINEAR;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsel_ff      <= fsel_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_valid) begin
         deriv1_ff  <= deriv1_in;
         x1_ff      <= x1_in;
         addr_a1_ff <= addr_a1_in;
         addr_b1_ff <= addr_b1_in;
         frac1_ff   <= frac1_in;
      end
      if (s2_free && v1_ff) begin
         deriv2_ff <= deriv1_ff;
         x2_ff     <= x1_ff;
         frac2_ff  <= frac1_ff;
         worda2_ff <= worda2_in;
         wordb2_ff <= wordb2_in;
      end
      if (s3_free && v2_ff) begin
         deriv3_ff <= deriv2_ff;
         x3_ff     <= x2_ff;
         a3_ff     <= a3_in;
         prod3_ff  <= prod3_in;
      end
      if (s4_free && v3_ff) begin
         deriv4_ff <= deriv3_ff;
         x4_ff     <= x3_ff;
         lut4_ff   <= lut4_in;
      end
      if (out_free && v4_ff) begin
         rsp_result_out_ff <= rsp_result_out_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_out = rsp_result_out_ff;

endmodule

// ----- hdl/nnau_checker.sv -----
// Port-level checker for the activation unit, bound into nn_activation_unit.
// Depends on nnau_pkg and nn_activation_unit_macros.svh.
`include "nn_activation_unit_macros.svh"

module nnau_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [nnau_pkg::DATA_W-1:0] rsp_result_out
);

   localparam int CW = $clog2(nnau_pkg::PIPE_DEPTH + 1);

   logic          req_take, rsp_take;
   logic [CW-1:0] pending_ff, pending_in;

   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + CW'(req_take) - CW'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `NNAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_out), "result changed while stalled")
   `NNAU_ASSERT_ALWAYS(a_pending_max, pending_ff <= CW'(nnau_pkg::PIPE_DEPTH), "more transactions in flight than stages")
   `NNAU_ASSERT_IMPLIES(a_no_orphan, rsp_valid, pending_ff != '0, "result without an accepted transaction")
   `NNAU_ASSERT_IMPLIES(a_idle_ready, pending_ff == '0, !req_stall, "stall raised while empty")

endmodule

bind nn_activation_unit nnau_checker u_nnau_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_result_out (rsp_result_out)
);
